[src/nps_pkg.sv]
package nps_pkg;

    // Search geometry
    localparam int NPS_MAX_POINTS = 1024;

    // Field widths
    localparam int COORD_W = 16;
    localparam int MAG_W   = 16;
    localparam int PROD_W  = 32;
    localparam int SQ_W    = 33;
    localparam int ROOT_W  = 17;
    localparam int INDEX_W = 10;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_QUERY_X = 1'b0,
        REG_QUERY_Y = 1'b1
    } nps_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_UPDATE,
        ST_ROOT_START,
        ST_ROOT_RUN
    } nps_state_t;

endpackage

[src/nps_sqrt.sv]
module nps_sqrt
    import nps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQ_W-1:0]   value,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    // Highest power of four that fits the radicand width
    localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (2 * ((SQ_W - 1) / 2));

    logic              busy_reg, busy_next;
    logic [SQ_W-1:0]   rem_reg, rem_next;
    logic [SQ_W-1:0]   root_reg, root_next;
    logic [SQ_W-1:0]   bit_reg, bit_next;
    logic [SQ_W:0]     trial;
    logic              take;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign take  = {1'b0, rem_reg} >= trial;

    always_comb begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            rem_next  = value;
            root_next = '0;
            bit_next  = TOP_BIT;
        end else if (busy_reg) begin
            // One result bit per cycle
            if (take) begin
                rem_next  = rem_reg - trial[SQ_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign busy = busy_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule

[src/nearest_point_search.sv]
// Nearest point search over a stream of 2D candidates, signed Q8.8.
//
// Program the query point through the APB port first: query_x at byte 0,
// query_y at byte 4 (low 16 bits of pwdata). Write only while the block is
// idle. Then stream candidates on the s_ channel, one per transaction; the
// transaction with s_tlast high closes the search. A search of one point
// is valid.
//
// Each candidate passes through the accept state, then the shared 16x16
// multiplier squares |dx| and |dy| in turn, then ST_UPDATE adds, compares
// and updates the best. s_tready is low from the accept through the update.
// After the last candidate the iterative square root runs (one result bit
// per cycle); m_tvalid rises when the root is done and the output register
// is free. The result then waits in the output register while the next
// search already streams in; if m_tready is still low when the next result
// is ready, the sequencer holds and s_tready stays low until the output
// register frees up.
// Reset clears the query point, the search state and m_tvalid.
module nearest_point_search
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = NPS_MAX_POINTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Candidate stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // point_x [15:0], point_y [31:16]
    input  logic                  s_tlast,  // last_point
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // nearest_index [9:0],
                                            // nearest_distance [26:10], zero [31:27]
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);

    // Configuration registers
    logic [COORD_W-1:0] query_x_reg;
    logic [COORD_W-1:0] query_y_reg;
    logic               cfg_write;

    // Sequencer and datapath state
    nps_state_t         state_reg, state_next;
    logic [MAG_W-1:0]   mag_x_reg, mag_y_reg;
    logic               last_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SQ_W-1:0]    best_square_reg;
    logic [IDX_W-1:0]   best_pos_reg;
    logic [IDX_W-1:0]   counter_reg;
    logic               first_reg;

    // Output register
    logic               m_tvalid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [ROOT_W-1:0]  out_dist_reg;

    // Combinational nets
    logic               s_accept;
    logic [COORD_W:0]   diff_x, diff_y;
    logic [COORD_W:0]   abs_x, abs_y;
    logic [MAG_W-1:0]   mul_op;
    logic [PROD_W-1:0]  mul_out;
    logic [SQ_W-1:0]    sum;
    logic               take;
    logic               root_start;
    logic               root_busy;
    logic [ROOT_W-1:0]  root_value;
    logic               out_free;
    logic               load_out;
    logic [IDX_W+INDEX_W-1:0] pos_ext;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end else if (cfg_write) begin
            unique case (nps_reg_t'(paddr[2]))
                REG_QUERY_X: query_x_reg <= pwdata[COORD_W-1:0];
                REG_QUERY_Y: query_y_reg <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (nps_reg_t'(paddr[2]))
            REG_QUERY_X: prdata = {{(APB_DATA_W-COORD_W){query_x_reg[COORD_W-1]}}, query_x_reg};
            REG_QUERY_Y: prdata = {{(APB_DATA_W-COORD_W){query_y_reg[COORD_W-1]}}, query_y_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- input capture ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Exact 17-bit differences, then magnitudes that fit 16 bits
    assign diff_x = {s_tdata[COORD_W-1], s_tdata[COORD_W-1:0]}
                  - {query_x_reg[COORD_W-1], query_x_reg};
    assign diff_y = {s_tdata[2*COORD_W-1], s_tdata[2*COORD_W-1:COORD_W]}
                  - {query_y_reg[COORD_W-1], query_y_reg};
    assign abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
    assign abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

    // ---------------- shared multiplier ----------------
    assign mul_op  = (state_reg == ST_MUL_X) ? mag_x_reg : mag_y_reg;
    assign mul_out = mul_op * mul_op;

    assign sum  = sq_reg + {1'b0, prod_reg};
    assign take = first_reg || (sum < best_square_reg);

    // ---------------- output slot ----------------
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        root_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = last_reg ? ST_ROOT_START : ST_IDLE;
            end
            ST_ROOT_START: begin
                root_start = 1'b1;
                state_next = ST_ROOT_RUN;
            end
            ST_ROOT_RUN: begin
                // Hold the finished root until the output register is free
                if (!root_busy && out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mag_x_reg <= abs_x[MAG_W-1:0];
            mag_y_reg <= abs_y[MAG_W-1:0];
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_MUL_X) begin
            sq_reg <= {1'b0, mul_out};
        end
        if (state_reg == ST_MUL_Y) begin
            prod_reg <= mul_out;
        end
    end

    // Search state: update on each candidate, clear once the result is out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_square_reg <= '0;
            best_pos_reg    <= '0;
            counter_reg     <= '0;
            first_reg       <= 1'b1;
        end else if (load_out) begin
            best_square_reg <= '0;
            best_pos_reg    <= '0;
            counter_reg     <= '0;
            first_reg       <= 1'b1;
        end else if (state_reg == ST_UPDATE) begin
            if (take) begin
                best_square_reg <= sum;
                best_pos_reg    <= counter_reg;
                first_reg       <= 1'b0;
            end
            // Saturate the index at the last slot
            if (counter_reg != LAST_IDX) begin
                counter_reg <= counter_reg + IDX_W'(1);
            end
        end
    end

    // ---------------- square root unit ----------------
    nps_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .value   (best_square_reg),
        .busy    (root_busy),
        .root    (root_value)
    );

    // ---------------- output register ----------------
    assign pos_ext = (IDX_W + INDEX_W)'(best_pos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (load_out) begin
            out_index_reg <= pos_ext[INDEX_W-1:0];
            out_dist_reg  <= root_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-INDEX_W-ROOT_W){1'b0}}, out_dist_reg, out_index_reg};

endmodule

[src/nps_checker.sv]
module nps_checker
    import nps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [ROOT_W-1:0] MAX_DIST = ROOT_W'(92681);

    // Reset leaves no result pending
    a_reset_clears_out: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("m_tvalid high after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
    ) else $error("result changed while stalled");

    // The block works on one candidate at a time
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("s_tready high right after an accepted candidate");

    // Distance never exceeds the root of the largest squared distance
    a_dist_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[INDEX_W+ROOT_W-1:INDEX_W] <= MAX_DIST)
                     && (m_tdata[M_TDATA_W-1:INDEX_W+ROOT_W] == '0)
    ) else $error("result distance out of range");

endmodule

bind nearest_point_search nps_checker u_nps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import nps_pkg::*;

    // One nearest-point result as it leaves the m_ channel
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [ROOT_W-1:0]  distance;
    } nearest_t;

    localparam int IDLE_PCT     = 27;
    localparam int STALL_CYCLES = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // point_x [15:0], point_y [31:16]
    logic                  s_tlast;   // last_point
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // nearest_index [9:0], nearest_distance [26:10]

    // Test control
    logic                  idle_on;
    logic                  rx_hold;
    event                  stall_go;
    int                    items_sent;
    int                    searches_sent;
    int                    results_seen;
    int                    chk_errors;
    int                    cfg_errors;

    // Predictor state
    logic [COORD_W-1:0]    model_qx;
    logic [COORD_W-1:0]    model_qy;
    logic [SQ_W-1:0]       model_best;
    int                    model_pos;
    int                    model_cnt;
    logic                  model_first;
    nearest_t              exp_q[$];

    nearest_point_search uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin : clk_gen
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        #(2_000_000);
        $error("run limit reached before the end of the test sequence");
        $display("** nearest_point_search: FAILED **");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic logic [ROOT_W-1:0] model_sqrt(input logic [SQ_W-1:0] v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem  = 64'(v);
        root = 0;
        b    = 64'd1 << 34;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return ROOT_W'(root);
    endfunction

    task automatic model_clear();
        model_best  = '0;
        model_pos   = 0;
        model_cnt   = 0;
        model_first = 1'b1;
    endtask

    task automatic model_step(input logic [15:0] px, input logic [15:0] py,
                              input logic is_last);
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        logic [COORD_W:0]        ax;
        logic [COORD_W:0]        ay;
        logic [SQ_W-1:0]         sq;
        int                      pos;
        nearest_t                res;
        dx  = {px[15], px} - {model_qx[15], model_qx};
        dy  = {py[15], py} - {model_qy[15], model_qy};
        ax  = dx[COORD_W] ? -dx : dx;
        ay  = dy[COORD_W] ? -dy : dy;
        sq  = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
        pos = (model_cnt > NPS_MAX_POINTS - 1) ? NPS_MAX_POINTS - 1 : model_cnt;
        if (model_first || sq < model_best) begin
            model_best  = sq;
            model_pos   = pos;
            model_first = 1'b0;
        end
        if (model_cnt < NPS_MAX_POINTS - 1) model_cnt++;
        if (is_last) begin
            res.index    = INDEX_W'(model_pos);
            res.distance = model_sqrt(model_best);
            exp_q.push_back(res);
            searches_sent++;
            model_clear();
        end
    endtask

    // ---------------- shared drivers ----------------
    // Enter at a falling edge, leave at a falling edge
    task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                              input logic is_last);
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = {py, px};
        s_tlast  = is_last;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        model_step(px, py, is_last);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
    endtask

    task automatic apb_write(input nps_reg_t reg_sel, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (reg_sel == REG_QUERY_X) model_qx = data[COORD_W-1:0];
        else model_qy = data[COORD_W-1:0];
    endtask

    task automatic apb_read_check(input nps_reg_t reg_sel, input logic [15:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {reg_sel, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata[COORD_W-1:0] !== want) begin
            $error("%s readback: expected %0h, actual %0h",
                   reg_sel.name(), want, prdata[COORD_W-1:0]);
            cfg_errors++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Pause the sender until every expected result has come out
    task automatic drain();
        while (exp_q.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_near(input logic [15:0] center, input int spread);
        return center + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
    endfunction

    task automatic send_search(input int len, input int spread);
        logic [15:0] px;
        logic [15:0] py;
        for (int i = 0; i < len; i++) begin
            if (spread == 0) begin
                px = 16'($urandom);
                py = 16'($urandom);
            end else begin
                px = rand_near(model_qx, spread);
                py = rand_near(model_qy, spread);
            end
            send_point(px, py, i == len - 1);
        end
    endtask

    task automatic set_query(input logic [15:0] qx, input logic [15:0] qy);
        drain();
        apb_write(REG_QUERY_X, {16'h0, qx});
        apb_write(REG_QUERY_Y, {16'h0, qy});
    endtask

    // ---------------- receiver ----------------
    initial begin : stall_proc
        int stall_count;
        rx_hold = 1'b0;
        forever begin
            @(stall_go);
            rx_hold = 1'b1;
            for (stall_count = 0; stall_count < STALL_CYCLES; stall_count++) begin
                @(negedge aclk);
            end
            rx_hold = 1'b0;
        end
    end

    initial begin : rx_ready_proc
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn || rx_hold) m_tready = 1'b0;
            else if (idle_on) m_tready = ($urandom_range(0, 99) >= IDLE_PCT);
            else m_tready = 1'b1;
        end
    end

    initial begin : result_check
        nearest_t exp_item;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (exp_q.size() == 0) begin
                    $error("nearest_index: expected no result, actual %0d",
                           m_tdata[INDEX_W-1:0]);
                    chk_errors++;
                end else begin
                    exp_item = exp_q.pop_front();
                    results_seen++;
                    if (m_tdata[INDEX_W-1:0] !== exp_item.index) begin
                        $error("nearest_index: expected %0d, actual %0d",
                               exp_item.index, m_tdata[INDEX_W-1:0]);
                        chk_errors++;
                    end
                    if (m_tdata[INDEX_W+ROOT_W-1:INDEX_W] !== exp_item.distance) begin
                        $error("nearest_distance: expected %0d, actual %0d",
                               exp_item.distance, m_tdata[INDEX_W+ROOT_W-1:INDEX_W]);
                        chk_errors++;
                    end
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_config_readback();
        apb_write(REG_QUERY_X, 32'hABCD_8001);
        apb_read_check(REG_QUERY_X, 16'h8001);
        apb_write(REG_QUERY_Y, 32'h0000_7FFE);
        apb_read_check(REG_QUERY_Y, 16'h7FFE);
        apb_read_check(REG_QUERY_X, 16'h8001);
        set_query(16'h0000, 16'h0000);
        apb_read_check(REG_QUERY_Y, 16'h0000);
    endtask

    task automatic test_single_point();
        for (int i = 0; i < 20; i++) begin
            if (i % 5 == 0) set_query(16'($urandom), 16'($urandom));
            send_search(1, 0);
        end
        drain();
    endtask

    task automatic test_ties();
        set_query(16'h0000, 16'h0000);
        send_point(16'(256), 16'(0), 1'b0);
        send_point(16'(0), 16'(256), 1'b0);
        send_point(16'(-256), 16'(0), 1'b0);
        send_point(16'(0), 16'(-256), 1'b1);
        send_point(16'(512), 16'(0), 1'b0);
        send_point(16'(0), 16'(100), 1'b0);
        send_point(16'(100), 16'(0), 1'b0);
        send_point(16'(-100), 16'(0), 1'b1);
        send_point(16'(3), 16'(4), 1'b0);
        send_point(16'(4), 16'(3), 1'b0);
        send_point(16'(0), 16'(-5), 1'b0);
        send_point(16'(-5), 16'(0), 1'b1);
        drain();
    endtask

    task automatic test_extremes();
        set_query(16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h7FFF, 1'b1);
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b1);
        set_query(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b1);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b1);
        set_query(16'h0000, 16'h8000);
        send_point(16'h8000, 16'h7FFF, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h0000, 16'h8000, 1'b1);
        drain();
    endtask

    task automatic test_random_searches();
        int target;
        target = items_sent + 300;
        while (items_sent < target) begin
            if ($urandom_range(0, 3) == 0) set_query(16'($urandom), 16'($urandom));
            send_search($urandom_range(1, 12), ($urandom_range(0, 1) == 0) ? 0 : 3);
        end
        drain();
    endtask

    task automatic test_back_to_back();
        int target;
        idle_on = 1'b0;
        target  = items_sent + 80;
        while (items_sent < target) begin
            send_search($urandom_range(1, 8), ($urandom_range(0, 1) == 0) ? 0 : 2);
        end
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        set_query(16'($urandom), 16'($urandom));
        -> stall_go;
        for (int i = 0; i < 20; i++) begin
            send_search(3, 0);
        end
        drain();
    endtask

    initial begin : main_seq
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        idle_on       = 1'b1;
        items_sent    = 0;
        searches_sent = 0;
        results_seen  = 0;
        chk_errors    = 0;
        cfg_errors    = 0;
        model_qx      = '0;
        model_qy      = '0;
        model_clear();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_config_readback();
        test_single_point();
        test_ties();
        test_extremes();
        test_random_searches();
        test_back_to_back();
        test_output_stall();
        drain();

        $display("Covered register readback, single-point, tied and extreme searches,");
        $display("random and gapless streams, and a long output stall: %0d points, %0d results.",
                 items_sent, results_seen);
        if (chk_errors == 0 && cfg_errors == 0 && exp_q.size() == 0) begin
            $display("** nearest_point_search: PASSED **");
        end else begin
            $display("** nearest_point_search: FAILED **");
        end
        $finish;
    end

endmodule
